// ===== sv/ltdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltdc_pkg
// Shared types and constants for the latency token depth controller.
// ----------------------------------------------------------------------------
package ltdc_pkg;

  localparam int unsigned LAT_W        = 40;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned READ_OUT_W   = 10;
  localparam int unsigned WRITE_OUT_W  = 8;
  localparam int unsigned OTHER_OUT_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_READ_TARGET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_TARGET = 1'b1;

  localparam logic [LAT_W-1:0] READ_TARGET_RST  = 40'd2000000;
  localparam logic [LAT_W-1:0] WRITE_TARGET_RST = 40'd10000000;

  typedef enum logic [2:0] {
    GR_NONE,
    GR_GREAT,
    GR_GOOD,
    GR_BAD,
    GR_AWFUL
  } grade_e;

  function automatic logic is_good(grade_e g);
    return (g == GR_GREAT) || (g == GR_GOOD);
  endfunction

  function automatic logic is_bad(grade_e g);
    return (g == GR_BAD) || (g == GR_AWFUL);
  endfunction

  // Higher of two present grades, GREAT > GOOD > BAD > AWFUL.
  function automatic grade_e best_grade(grade_e a, grade_e b);
    grade_e r;
    if (a == GR_GREAT || b == GR_GREAT) r = GR_GREAT;
    else if (a == GR_GOOD || b == GR_GOOD) r = GR_GOOD;
    else if (a == GR_BAD || b == GR_BAD) r = GR_BAD;
    else r = GR_AWFUL;
    return r;
  endfunction

endpackage

// ===== sv/ltdc_grade.sv =====
// ----------------------------------------------------------------------------
// ltdc_grade
// Grades one mean latency against its target.
// ----------------------------------------------------------------------------
module ltdc_grade import ltdc_pkg::*; (
  input  logic             present_i,
  input  logic [LAT_W-1:0] latency_i,
  input  logic [LAT_W-1:0] target_i,
  output grade_e           grade_o
);

  logic [LAT_W:0]   twice;
  logic [LAT_W-1:0] half;

  assign twice = {target_i, 1'b0};
  assign half  = target_i >> 1;

  always_comb begin
    if (!present_i) begin
      grade_o = GR_NONE;
    end else if ({1'b0, latency_i} >= twice) begin
      grade_o = GR_AWFUL;
    end else if (latency_i > target_i) begin
      grade_o = GR_BAD;
    end else if (latency_i <= half) begin
      grade_o = GR_GREAT;
    end else begin
      grade_o = GR_GOOD;
    end
  end

endmodule

// ===== sv/ltdc_rw_adj.sv =====
// ----------------------------------------------------------------------------
// ltdc_rw_adj
// Next token depth of the read or sync write domain, clamped to 1..MAX_DEPTH.
// ----------------------------------------------------------------------------
module ltdc_rw_adj import ltdc_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 512,
  localparam int unsigned DW       = $clog2(MAX_DEPTH + 3)
) (
  input  logic [DW-1:0] depth_i,
  input  grade_e        self_i,
  input  grade_e        peer_i,
  output logic [DW-1:0] depth_o
);

  logic [DW-1:0] step8;
  logic [DW-1:0] step4;
  logic [DW-1:0] raw;

  always_comb begin
    step8 = depth_i >> 3;
    if (step8 == '0) step8 = DW'(1);
    step4 = depth_i >> 2;
    if (step4 == '0) step4 = DW'(1);

    if (peer_i == GR_NONE) begin
      raw = depth_i + DW'(1);
    end else begin
      case (self_i)
        GR_GOOD:  raw = depth_i - step8;
        GR_GREAT: raw = depth_i - step4;
        GR_BAD:   raw = depth_i + DW'(1);
        default:  raw = depth_i + DW'(2);
      endcase
    end

    // hold on no samples or when both domains agree
    if (self_i == GR_NONE || (is_good(self_i) && is_good(peer_i)) ||
        (is_bad(self_i) && is_bad(peer_i))) begin
      depth_o = depth_i;
    end else if (raw == '0) begin
      depth_o = DW'(1);
    end else if (raw > DW'(MAX_DEPTH)) begin
      depth_o = DW'(MAX_DEPTH);
    end else begin
      depth_o = raw;
    end
  end

endmodule

// ===== sv/latency_token_depth_controller.sv =====
// Pipeline: an accepted beat is registered in the grade stage, then its result
// is loaded into the depth/result stage. Throughput: one beat per cycle unless
// an untaken result stalls the pipeline; the depth registers update as a result is loaded.
// Reset: targets return to 2 ms read and 10 ms write, depths to their maxima,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
// latency_token_depth_controller
// Grades each statistics window and steers the three token depths.
// ----------------------------------------------------------------------------
module latency_token_depth_controller import ltdc_pkg::*; #(
  parameter int unsigned READ_MAX_DEPTH  = 512,
  parameter int unsigned WRITE_MAX_DEPTH = 128,
  parameter int unsigned OTHER_MAX_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [LAT_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [LAT_W-1:0]       read_mean_latency_i,
  input  logic                   read_has_samples_i,
  input  logic [LAT_W-1:0]       write_mean_latency_i,
  input  logic                   write_has_samples_i,
  input  logic                   other_has_samples_i,
  input  logic                   stats_active_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [READ_OUT_W-1:0]  read_depth_out_o,
  output logic [WRITE_OUT_W-1:0] write_depth_out_o,
  output logic [OTHER_OUT_W-1:0] other_depth_out_o,
  output logic                   start_window_o
);

  localparam int unsigned RDW = $clog2(READ_MAX_DEPTH + 3);
  localparam int unsigned WDW = $clog2(WRITE_MAX_DEPTH + 3);
  localparam int unsigned ODW = $clog2(OTHER_MAX_DEPTH + 3);

  logic [LAT_W-1:0] read_target_q, write_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_target_q  <= READ_TARGET_RST;
      write_target_q <= WRITE_TARGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_READ_TARGET:  read_target_q  <= cfg_wdata_i;
        CFG_WRITE_TARGET: write_target_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Grade stage
  grade_e rd_grade_d, wr_grade_d;
  grade_e rd_grade_q, wr_grade_q;
  logic   other_q, active_q, s1_valid_q;
  logic   s1_move, in_fire;

  ltdc_grade u_rd_grade (
    .present_i (read_has_samples_i),
    .latency_i (read_mean_latency_i),
    .target_i  (read_target_q),
    .grade_o   (rd_grade_d)
  );

  ltdc_grade u_wr_grade (
    .present_i (write_has_samples_i),
    .latency_i (write_mean_latency_i),
    .target_i  (write_target_q),
    .grade_o   (wr_grade_d)
  );

  assign s1_move    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_grade_q <= rd_grade_d;
      wr_grade_q <= wr_grade_d;
      other_q    <= other_has_samples_i;
      active_q   <= stats_active_i;
    end
  end

  // Depth stage
  logic [RDW-1:0] read_depth_q, read_depth_d;
  logic [WDW-1:0] write_depth_q, write_depth_d;
  logic [ODW-1:0] other_depth_q, other_depth_d, other_raw, other_step4;
  grade_e         other_grade;
  logic           start_d, start_q;

  ltdc_rw_adj #(.MAX_DEPTH(READ_MAX_DEPTH)) u_rd_adj (
    .depth_i (read_depth_q),
    .self_i  (rd_grade_q),
    .peer_i  (wr_grade_q),
    .depth_o (read_depth_d)
  );

  ltdc_rw_adj #(.MAX_DEPTH(WRITE_MAX_DEPTH)) u_wr_adj (
    .depth_i (write_depth_q),
    .self_i  (wr_grade_q),
    .peer_i  (rd_grade_q),
    .depth_o (write_depth_d)
  );

  always_comb begin
    if (rd_grade_q == GR_NONE) other_grade = wr_grade_q;
    else if (wr_grade_q == GR_NONE) other_grade = rd_grade_q;
    else other_grade = best_grade(rd_grade_q, wr_grade_q);

    other_step4 = other_depth_q >> 2;
    if (other_step4 == '0) other_step4 = ODW'(1);

    if (rd_grade_q == GR_NONE && wr_grade_q == GR_NONE) begin
      other_raw = other_depth_q + ODW'(2);
    end else if (other_q) begin
      case (other_grade)
        GR_GREAT: other_raw = other_depth_q + ODW'(2);
        GR_GOOD:  other_raw = other_depth_q + ODW'(1);
        GR_BAD:   other_raw = other_depth_q - other_step4;
        default:  other_raw = other_depth_q >> 1;
      endcase
    end else begin
      other_raw = other_depth_q;
    end

    if (other_raw == '0) other_depth_d = ODW'(1);
    else if (other_raw > ODW'(OTHER_MAX_DEPTH)) other_depth_d = ODW'(OTHER_MAX_DEPTH);
    else other_depth_d = other_raw;

    start_d = !active_q && (is_bad(rd_grade_q) || is_bad(wr_grade_q) ||
                            (other_depth_d < ODW'(OTHER_MAX_DEPTH)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_depth_q  <= RDW'(READ_MAX_DEPTH);
      write_depth_q <= WDW'(WRITE_MAX_DEPTH);
      other_depth_q <= ODW'(OTHER_MAX_DEPTH);
      out_valid_o   <= 1'b0;
    end else begin
      if (s1_move) begin
        read_depth_q  <= read_depth_d;
        write_depth_q <= write_depth_d;
        other_depth_q <= other_depth_d;
      end
      // drop the beat once taken, load the next one when it moves up
      if (s1_move) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      start_q <= start_d;
    end
  end

  assign read_depth_out_o  = READ_OUT_W'(read_depth_q);
  assign write_depth_out_o = WRITE_OUT_W'(write_depth_q);
  assign other_depth_out_o = OTHER_OUT_W'(other_depth_q);
  assign start_window_o    = start_q;

endmodule
